@@ rtl/b32k_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b32k_pkg
// Shared constants, beat type and alphabet lookup for the base-32 key encoder.
// ----------------------------------------------------------------------------
package b32k_pkg;

    localparam int unsigned WORD_W          = 64;
    localparam int unsigned CHAR_W          = 7;
    localparam int unsigned DIGIT_W         = 5;
    localparam int unsigned POS_W           = 6;
    localparam int unsigned PHASE_W         = 3;
    localparam int unsigned DCNT_W          = 5;

    localparam logic [POS_W-1:0]   TEXT_LEN        = 6'd32;
    localparam logic [POS_W-1:0]   LAST_POS        = 6'd33;
    localparam logic [POS_W-1:0]   SUM_LIMIT       = 6'd30;
    localparam logic [PHASE_W-1:0] DASH_PHASE      = 3'd4;
    localparam logic [DCNT_W-1:0]  DIGITS_PER_WORD = 5'd13;
    localparam logic [CHAR_W-1:0]  DASH_CHAR       = 7'd45;

    localparam logic [255:0] ALPHABET = "1GZRSY3PD4J29TLM0XAF5ENB8UVH7CK6";

    typedef struct packed {
        logic [CHAR_W-1:0] text_char;
        logic              last_char;
    } beat_t;

    function automatic logic [CHAR_W-1:0] letter(input logic [DIGIT_W-1:0] digit);
        logic [7:0] base;
        base   = {~digit, 3'b000};
        letter = ALPHABET[base +: CHAR_W];
    endfunction

endpackage

@@ rtl/b32k_emitter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b32k_emitter
// Holds one key and walks its 34 text positions, one character per beat,
// keeping the two running check sums.
// ----------------------------------------------------------------------------
module b32k_emitter
    import b32k_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  logic [WORD_W-1:0] key_low_word,
    input  logic [WORD_W-1:0] key_high_word,
    output logic              can_load,
    output logic              beat_valid,
    input  logic              beat_ready,
    output beat_t             beat
);

    logic                busy_reg,  busy_next;
    logic [POS_W-1:0]    pos_reg,   pos_next;
    logic [PHASE_W-1:0]  phase_reg, phase_next;
    logic [DCNT_W-1:0]   dcnt_reg,  dcnt_next;
    logic [WORD_W-1:0]   low_reg,   low_next;
    logic [WORD_W-1:0]   high_reg,  high_next;
    logic [DIGIT_W-1:0]  even_reg,  even_next;
    logic [DIGIT_W-1:0]  odd_reg,   odd_next;

    logic [CHAR_W-1:0]   ch;
    logic                is_dash;
    logic                use_low;
    logic                is_last;
    logic                advance;

    assign is_dash = (phase_reg == DASH_PHASE);
    assign use_low = (dcnt_reg < DIGITS_PER_WORD);
    assign is_last = (pos_reg == LAST_POS);
    assign advance = busy_reg && beat_ready;

    always_comb begin
        if (pos_reg >= TEXT_LEN) begin
            ch = letter(pos_reg[0] ? odd_reg : even_reg);
        end else if (is_dash) begin
            ch = DASH_CHAR;
        end else if (use_low) begin
            ch = letter(low_reg[DIGIT_W-1:0]);
        end else begin
            ch = letter(high_reg[DIGIT_W-1:0]);
        end
    end

    assign beat_valid     = busy_reg;
    assign beat.text_char = ch;
    assign beat.last_char = is_last;
    assign can_load       = !busy_reg || (advance && is_last);

    always_comb begin
        busy_next  = busy_reg;
        pos_next   = pos_reg;
        phase_next = phase_reg;
        dcnt_next  = dcnt_reg;
        low_next   = low_reg;
        high_next  = high_reg;
        even_next  = even_reg;
        odd_next   = odd_reg;
        if (load) begin
            busy_next  = 1'b1;
            pos_next   = '0;
            phase_next = '0;
            dcnt_next  = '0;
            low_next   = key_low_word;
            high_next  = key_high_word;
            even_next  = '0;
            odd_next   = '0;
        end else if (advance) begin
            pos_next   = pos_reg + 6'd1;
            phase_next = is_dash ? '0 : phase_reg + 3'd1;
            if (is_last) begin
                busy_next = 1'b0;
                pos_next  = '0;
            end
            if ((pos_reg < TEXT_LEN) && !is_dash) begin
                dcnt_next = dcnt_reg + 5'd1;
                if (use_low) begin
                    low_next = low_reg >> DIGIT_W;
                end else begin
                    high_next = high_reg >> DIGIT_W;
                end
            end
            if (pos_reg < SUM_LIMIT) begin
                if (pos_reg[0]) begin
                    odd_next = odd_reg + ch[DIGIT_W-1:0];
                end else begin
                    even_next = even_reg + ch[DIGIT_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            pos_reg   <= '0;
            phase_reg <= '0;
            dcnt_reg  <= '0;
            even_reg  <= '0;
            odd_reg   <= '0;
        end else begin
            busy_reg  <= busy_next;
            pos_reg   <= pos_next;
            phase_reg <= phase_next;
            dcnt_reg  <= dcnt_next;
            even_reg  <= even_next;
            odd_reg   <= odd_next;
        end
    end

    always_ff @(posedge aclk) begin
        low_reg  <= low_next;
        high_reg <= high_next;
    end

endmodule

@@ rtl/b32k_out_reg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b32k_out_reg
// Output register stage: holds one character beat for the result channel.
// ----------------------------------------------------------------------------
module b32k_out_reg
    import b32k_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    input  beat_t in_beat,
    output logic  out_valid,
    input  logic  out_ready,
    output beat_t out_beat
);

    logic  valid_reg, valid_next;
    beat_t beat_reg,  beat_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_beat  = beat_reg;

    always_comb begin
        valid_next = valid_reg;
        beat_next  = beat_reg;
        if (in_ready) begin
            valid_next = in_valid;
            beat_next  = in_beat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        beat_reg <= beat_next;
    end

endmodule

@@ rtl/base32_key_text_encoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base32_key_text_encoder
// Encodes a 128-bit key into a 34-character base-32 text code with dashes
// and two check letters.
//
//   channel | ports                                   | per beat
//   --------+-----------------------------------------+----------------------
//   s_      | s_valid s_ready s_key_low_word          | one 128-bit key
//           | s_key_high_word                         |
//   m_      | m_valid m_ready m_text_char m_last_char | one character
//
// One character per cycle, unless m_ready stalls, leaves the emitter through
// the output register. The next key is taken in the cycle the last character
// of the current one moves out of the emitter, so codes follow without a gap.
// Reset empties the emitter and output register. A stall on m_ready holds the
// current character and the emitter; s_ready drops until the code completes.
// ----------------------------------------------------------------------------
module base32_key_text_encoder
    import b32k_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [WORD_W-1:0] s_key_low_word,
    input  logic [WORD_W-1:0] s_key_high_word,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [CHAR_W-1:0] m_text_char,
    output logic              m_last_char
);

    logic  can_load;
    logic  beat_valid;
    logic  beat_ready;
    beat_t beat;
    beat_t out_beat;

    assign s_ready = can_load;

    b32k_emitter u_emitter (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .load          (s_valid && can_load),
        .key_low_word  (s_key_low_word),
        .key_high_word (s_key_high_word),
        .can_load      (can_load),
        .beat_valid    (beat_valid),
        .beat_ready    (beat_ready),
        .beat          (beat)
    );

    b32k_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (beat_valid),
        .in_ready  (beat_ready),
        .in_beat   (beat),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_beat  (out_beat)
    );

    assign m_text_char = out_beat.text_char;
    assign m_last_char = out_beat.last_char;

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for base32_key_text_encoder. A driver sends 128-bit keys
// on the s_ channel with random gaps. A monitor takes characters on the m_
// channel with random stalls. Every character is checked in order against a
// predicted 34-character code with dashes and two check letters.
// ----------------------------------------------------------------------------
module tb_top
    import b32k_pkg::*;
();

    typedef struct packed {
        logic [WORD_W-1:0] low_word;
        logic [WORD_W-1:0] high_word;
    } key_t;

    localparam logic [8*32-1:0] CODE_ALPHABET = "1GZRSY3PD4J29TLM0XAF5ENB8UVH7CK6";
    localparam int unsigned     CODE_CHARS    = 34;
    localparam int unsigned     RANDOM_KEYS   = 468;
    localparam int unsigned     CYCLE_LIMIT   = 1_000_000;
    localparam int unsigned     DRAIN_CYCLES  = 80;
    localparam int unsigned     MAX_REPORTS   = 10;

    logic              aclk            = 1'b0;
    logic              aresetn         = 1'b0;
    logic              s_valid         = 1'b0;
    logic              s_ready;
    logic [WORD_W-1:0] s_key_low_word  = '0;
    logic [WORD_W-1:0] s_key_high_word = '0;
    logic              m_valid;
    logic              m_ready         = 1'b0;
    logic [CHAR_W-1:0] m_text_char;
    logic              m_last_char;

    key_t  key_q[$];
    beat_t code_q[$];

    int unsigned mismatch_cnt = 0;
    int unsigned char_cnt     = 0;
    int unsigned cycle_cnt    = 0;
    int unsigned send_wait    = 0;
    int unsigned recv_wait    = 0;
    int unsigned wait_draw;
    bit          send_calm    = 1'b0;
    bit          recv_calm    = 1'b1;
    key_t        next_key;
    beat_t       want;

    base32_key_text_encoder u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_key_low_word  (s_key_low_word),
        .s_key_high_word (s_key_high_word),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_text_char     (m_text_char),
        .m_last_char     (m_last_char)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic logic [CHAR_W-1:0] code_letter(input logic [DIGIT_W-1:0] digit);
        int unsigned idx;
        idx = digit;
        return CODE_ALPHABET[8*(31-idx) +: CHAR_W];
    endfunction

    function automatic int unsigned draw_wait(inout bit calm);
        if ($urandom_range(0, 15) == 0) begin
            calm = ~calm;
        end
        return calm ? 0 : $urandom_range(0, 10);
    endfunction

    function automatic logic [WORD_W-1:0] digit_ramp(input int unsigned first);
        logic [WORD_W-1:0] w;
        w = '0;
        for (int unsigned i = 0; i < 13; i++) begin
            w = w | (WORD_W'((first + i) % 32) << (5 * i));
        end
        return w;
    endfunction

    function automatic logic [WORD_W-1:0] random_word();
        return {$urandom, $urandom};
    endfunction

    task automatic predict_code(input logic [WORD_W-1:0] low_word,
                                input logic [WORD_W-1:0] high_word);
        logic [WORD_W-1:0]  shift_low;
        logic [WORD_W-1:0]  shift_high;
        logic [DIGIT_W-1:0] even_acc;
        logic [DIGIT_W-1:0] odd_acc;
        logic [CHAR_W-1:0]  ch;
        int unsigned        digits;
        int unsigned        pos;
        shift_low  = low_word;
        shift_high = high_word;
        even_acc   = '0;
        odd_acc    = '0;
        digits     = 0;
        for (pos = 0; pos < TEXT_LEN; pos++) begin
            if (pos % 5 == DASH_PHASE) begin
                ch = DASH_CHAR;
            end else if (digits < DIGITS_PER_WORD) begin
                ch        = code_letter(shift_low[DIGIT_W-1:0]);
                shift_low = shift_low >> DIGIT_W;
                digits++;
            end else begin
                ch         = code_letter(shift_high[DIGIT_W-1:0]);
                shift_high = shift_high >> DIGIT_W;
                digits++;
            end
            if (pos < SUM_LIMIT) begin
                if (pos[0] == 1'b0) begin
                    even_acc = even_acc + ch[DIGIT_W-1:0];
                end else begin
                    odd_acc = odd_acc + ch[DIGIT_W-1:0];
                end
            end
            code_q.push_back('{text_char: ch, last_char: 1'b0});
        end
        code_q.push_back('{text_char: code_letter(even_acc), last_char: 1'b0});
        code_q.push_back('{text_char: code_letter(odd_acc), last_char: 1'b1});
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid   <= 1'b0;
            send_wait <= 0;
        end else begin
            if (s_valid && s_ready) begin
                predict_code(s_key_low_word, s_key_high_word);
            end
            if (!s_valid || s_ready) begin
                if (send_wait != 0) begin
                    s_valid   <= 1'b0;
                    send_wait <= send_wait - 1;
                end else if (key_q.size() != 0) begin
                    next_key        = key_q.pop_front();
                    s_valid         <= 1'b1;
                    s_key_low_word  <= next_key.low_word;
                    s_key_high_word <= next_key.high_word;
                    send_wait       <= draw_wait(send_calm);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready   <= 1'b0;
            recv_wait <= 0;
        end else if (m_valid && m_ready) begin
            if (code_q.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= MAX_REPORTS) begin
                    $display("unexpected beat %0d: char %0d last %0b", char_cnt,
                             m_text_char, m_last_char);
                end
            end else begin
                want = code_q.pop_front();
                if (m_text_char !== want.text_char || m_last_char !== want.last_char) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= MAX_REPORTS) begin
                        $display("beat %0d: char exp %0d got %0d, last exp %0b got %0b",
                                 char_cnt, want.text_char, m_text_char,
                                 want.last_char, m_last_char);
                    end
                end
            end
            char_cnt++;
            wait_draw = draw_wait(recv_calm);
            recv_wait <= wait_draw;
            m_ready   <= (wait_draw == 0);
        end else if (!m_ready) begin
            if (recv_wait <= 1) begin
                m_ready   <= 1'b1;
                recv_wait <= 0;
            end else begin
                recv_wait <= recv_wait - 1;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        int unsigned pick;
        int unsigned drain;
        key_t        k;

        key_q.push_back('{low_word: '0, high_word: '0});
        key_q.push_back('{low_word: '1, high_word: '1});
        key_q.push_back('{low_word: '1, high_word: '0});
        key_q.push_back('{low_word: '0, high_word: '1});
        key_q.push_back('{low_word: 64'hAAAA_AAAA_AAAA_AAAA, high_word: 64'h5555_5555_5555_5555});
        key_q.push_back('{low_word: 64'h5555_5555_5555_5555, high_word: 64'hAAAA_AAAA_AAAA_AAAA});
        key_q.push_back('{low_word: digit_ramp(0), high_word: digit_ramp(13)});
        key_q.push_back('{low_word: digit_ramp(26), high_word: digit_ramp(7)});
        key_q.push_back('{low_word: 64'hF000_0000_0000_0000, high_word: 64'h8000_0000_0000_0000});
        key_q.push_back('{low_word: 64'h0FFF_FFFF_FFFF_FFFF, high_word: 64'h7FFF_FFFF_FFFF_FFFF});
        key_q.push_back('{low_word: 64'd1, high_word: 64'd1});
        key_q.push_back('{low_word: 64'd31, high_word: 64'd30});

        for (int unsigned n = 0; n < RANDOM_KEYS; n++) begin
            pick = $urandom_range(0, 9);
            if (pick <= 6) begin
                k.low_word  = random_word();
                k.high_word = random_word();
            end else if (pick == 7) begin
                k.low_word  = WORD_W'(1) << $urandom_range(0, 63);
                k.high_word = WORD_W'(1) << $urandom_range(0, 63);
            end else if (pick == 8) begin
                k.low_word  = ~(WORD_W'(1) << $urandom_range(0, 63));
                k.high_word = ~(WORD_W'(1) << $urandom_range(0, 63));
            end else begin
                k.low_word  = random_word() & 64'hF000_0000_0000_0000;
                k.high_word = random_word() & 64'hF000_0000_0000_0000;
            end
            key_q.push_back(k);
        end

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        while (key_q.size() != 0 || s_valid) @(posedge aclk);
        while (code_q.size() != 0) @(posedge aclk);
        for (drain = 0; drain < DRAIN_CYCLES; drain++) @(posedge aclk);

        if (mismatch_cnt == 0 && code_q.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/b32k_pkg.sv
rtl/b32k_emitter.sv
rtl/b32k_out_reg.sv
rtl/base32_key_text_encoder.sv
tb/tb_top.sv
